// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/gbc_pkg.sv =====
package gbc_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int LineRows  = 5;
  localparam int SlotW     = 3;
  localparam int PixW      = 8;
  localparam int CfgW      = 12;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam int OpqDepth = 4;
  localparam int OpqPtrW  = $clog2(OpqDepth);
  localparam int OutDepth = 8;
  localparam int OutPtrW  = $clog2(OutDepth);

  // Division by 159 as a multiply by ceil(2^24 / 159); exact for sums below 2^16.
  localparam int RowSumW  = 14;
  localparam int SumW     = 16;
  localparam int DivShift = 24;
  localparam int ProdW    = 33;
  localparam logic [16:0] DivMul = 17'd105518;

  localparam logic [3:0] Kern [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  typedef logic [PixW-1:0] pix_t;
  typedef logic [LineRows-1:0][PixW-1:0] col_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FIRST,
    OP_SHIFT
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    col_t               col;
    logic               emit;
    logic               last;
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    column;
    logic [SlotW-1:0]   slot;
    logic [1:0]         off;
    logic [2:0]         rlim;
    logic [1:0]         step;
  } op_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic            last;
  } meta_t;

  typedef struct packed {
    pix_t  blurred;
    meta_t meta;
  } res_t;

  // Line-store slot holding kernel tap row d of the output row that lies off rows
  // above the newest input row; rows above the top of the frame fold onto row 0.
  function automatic logic [SlotW-1:0] slot_sel(input logic [SlotW-1:0] slot,
                                                input logic [1:0] off,
                                                input logic [2:0] rlim,
                                                input logic [2:0] d);
    logic [3:0] reach;
    logic [3:0] up;
    logic [3:0] s;
    reach = 4'(off) + 4'd2;
    up = (reach >= 4'(d)) ? reach - 4'(d) : 4'd0;
    if (up > 4'(rlim)) up = 4'(rlim);
    s = 4'(slot) + 4'd5 - up;
    if (s >= 4'd5) s = s - 4'd5;
    return s[SlotW-1:0];
  endfunction

endpackage

// ===== src/gbc_front.sv =====
module gbc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gbc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [gbc_pkg::CfgW-1:0]       cfg_data,
  input  logic                           in_push,
  input  gbc_pkg::pix_t                  in_pixel,
  output logic                           in_full,
  input  logic                           opq_full,
  output logic                           opq_push,
  output gbc_pkg::op_t                   opq_data
);
  import gbc_pkg::*;

  function automatic logic [ColW-1:0] dim_m1(input logic [CfgW-1:0] v,
                                             input logic [CfgW-1:0] vmax);
    logic [ColW-1:0] r;
    if (v == '0) r = '0;
    else if (v > vmax) r = ColW'(vmax - 1'b1);
    else r = ColW'(v - 1'b1);
    return r;
  endfunction

  logic [ColW-1:0]  w_m1_r;
  logic [RowW-1:0]  h_m1_r;
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic [SlotW-1:0] slot_r;

  logic             cur_v_r;
  logic [ColW-1:0]  cur_col_r;
  logic [RowW-1:0]  cur_row_r;
  logic [SlotW-1:0] cur_slot_r;
  pix_t             cur_pix_r;
  logic             cur_cl_r;
  logic             cur_rl_r;
  logic [2:0]       cur_rlim_r;
  logic [1:0]       step_r;
  logic [1:0]       off_r;

  pix_t             mem [LineRows][MaxWidth];
  col_t             rd_r;
  col_t             colv;

  logic             acc;
  logic             no_ops;
  logic             any_emit;
  logic [ColW:0]    k;
  logic             emit;
  logic [1:0]       off_hi;
  logic [1:0]       off_end;
  logic [1:0]       new_off_hi;
  logic [1:0]       step_start;
  logic             step_end;
  logic             fin;
  logic             done_now;
  logic             col_last;
  logic             row_last;

  assign acc      = in_push && !in_full;
  assign col_last = (col_r == w_m1_r);
  assign row_last = (row_r == h_m1_r);

  // Current item: output rows are issued one after another, and within a row the
  // column steps; only the very first op loads the window, the later ones reuse it.
  always_comb begin
    no_ops   = !cur_rl_r && (cur_row_r < RowW'(2));
    any_emit = !no_ops && (cur_cl_r || (cur_col_r >= ColW'(2)));
    k        = {1'b0, cur_col_r} + (ColW+1)'(step_r);
    emit     = (k >= (ColW+1)'(2)) && !no_ops;
    off_hi   = cur_rl_r ? ((cur_row_r >= RowW'(2)) ? 2'd2 : cur_row_r[1:0]) : 2'd2;
    off_end  = cur_rl_r ? 2'd0 : 2'd2;
    // Later rows skip the column steps that lie left of the frame.
    step_start = (cur_col_r == '0) ? 2'd2 : ((cur_col_r == ColW'(1)) ? 2'd1 : 2'd0);
    step_end = cur_cl_r ? (step_r == 2'd2) : (step_r == 2'd0);
    fin      = step_end && (!any_emit || (off_r == off_end));
    opq_push = cur_v_r && !no_ops && !opq_full;
    done_now = cur_v_r && (no_ops || (opq_push && fin));
    in_full  = cur_v_r && !done_now;
    new_off_hi = row_last ? ((row_r >= RowW'(2)) ? 2'd2 : row_r[1:0]) : 2'd2;
  end

  // The pixel just written is not yet visible in the registered read data.
  always_comb begin
    for (int b = 0; b < LineRows; b++) begin
      colv[b] = (cur_slot_r == SlotW'(b)) ? cur_pix_r : rd_r[b];
    end
  end

  always_comb begin
    opq_data.col    = colv;
    opq_data.emit   = emit;
    opq_data.last   = emit && fin;
    opq_data.row    = cur_row_r - RowW'(off_r);
    opq_data.column = ColW'(k - (ColW+1)'(2));
    opq_data.slot   = cur_slot_r;
    opq_data.off    = off_r;
    opq_data.rlim   = cur_rlim_r;
    opq_data.step   = step_r;
    if ((step_r != 2'd0) || (off_r != off_hi)) begin
      opq_data.kind = OP_HOLD;
    end else if (cur_col_r == '0) begin
      opq_data.kind = OP_FIRST;
    end else begin
      opq_data.kind = OP_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int b = 0; b < LineRows; b++) begin
        rd_r[b] <= mem[b][col_r];
        if (slot_r == SlotW'(b)) mem[b][col_r] <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r  <= ColW'(MaxWidth - 1);
      h_m1_r  <= RowW'(MaxHeight - 1);
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      cur_v_r <= 1'b0;
      step_r  <= '0;
      off_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == RegFrameWidth || cfg_index == RegFrameHeight)) begin
        if (cfg_index == RegFrameWidth) begin
          w_m1_r <= dim_m1(cfg_data, CfgW'(MaxWidth));
        end else begin
          h_m1_r <= RowW'(dim_m1(cfg_data, CfgW'(MaxHeight)));
        end
        col_r  <= '0;
        row_r  <= '0;
        slot_r <= '0;
      end else if (acc) begin
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r  <= '0;
            slot_r <= '0;
          end else begin
            row_r  <= row_r + 1'b1;
            slot_r <= (slot_r == SlotW'(LineRows - 1)) ? '0 : slot_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end

      if (acc) begin
        cur_v_r    <= 1'b1;
        cur_col_r  <= col_r;
        cur_row_r  <= row_r;
        cur_slot_r <= slot_r;
        cur_pix_r  <= in_pixel;
        cur_cl_r   <= col_last;
        cur_rl_r   <= row_last;
        cur_rlim_r <= (row_r > RowW'(4)) ? 3'd4 : row_r[2:0];
        step_r     <= '0;
        off_r      <= new_off_hi;
      end else if (done_now) begin
        cur_v_r <= 1'b0;
      end else if (opq_push) begin
        if (step_end) begin
          step_r <= step_start;
          off_r  <= off_r - 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/gbc_opq.sv =====
module gbc_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gbc_pkg::op_t  push_data,
  output logic          full,
  input  logic          pop,
  output gbc_pkg::op_t  pop_data,
  output logic          empty
);
  import gbc_pkg::*;

  op_t                q [OpqDepth];
  logic [OpqPtrW-1:0] wr_ptr_r;
  logic [OpqPtrW-1:0] rd_ptr_r;
  logic [OpqPtrW:0]   cnt_r;

  assign full     = (cnt_r == (OpqPtrW+1)'(OpqDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (OpqPtrW+1)'(push) - (OpqPtrW+1)'(pop);
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(opq_no_overflow, clk, rst_n, push && full, "op queue written while full")
  `ASSERT_NEVER(opq_no_underflow, clk, rst_n, pop && empty, "op queue read while empty")

endmodule

// ===== src/gbc_back.sv =====
module gbc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        opq_empty,
  input  gbc_pkg::op_t                opq_data,
  output logic                        opq_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output gbc_pkg::pix_t               out_blurred,
  output logic [gbc_pkg::RowW-1:0]    out_row,
  output logic [gbc_pkg::ColW-1:0]    out_col,
  output logic                        out_last_of_run
);
  import gbc_pkg::*;

  // Window of the five stored rows over five columns; column 4 is the newest.
  col_t [4:0]          win_r;

  logic                e0_v_r;
  meta_t               e0_meta_r;
  logic [SlotW-1:0]    e0_slot_r;
  logic [1:0]          e0_off_r;
  logic [2:0]          e0_rlim_r;
  logic [1:0]          e0_step_r;
  logic                e1_v_r;
  meta_t               e1_meta_r;
  logic [RowSumW-1:0]  rs_r [5];
  logic [RowSumW-1:0]  rs_nxt [5];
  logic                e2_v_r;
  meta_t               e2_meta_r;
  logic [SumW-1:0]     sum_r;
  logic                e3_v_r;
  meta_t               e3_meta_r;
  logic [ProdW-1:0]    prod_r;

  res_t                ofifo [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_r;
  logic [OutPtrW-1:0]  rd_ptr_r;
  logic [OutPtrW:0]    cnt_r;
  logic [2:0]          inflight;
  logic                rd;
  res_t                head;
  res_t                wr_res;

  assign inflight = 3'(e0_v_r) + 3'(e1_v_r) + 3'(e2_v_r) + 3'(e3_v_r);
  // Only take an op when every result already in the pipe still has a place.
  assign opq_pop  = !opq_empty &&
                    (({1'b0, cnt_r} + (OutPtrW+2)'(inflight)) < (OutPtrW+2)'(OutDepth));
  assign out_empty = (cnt_r == '0);
  assign rd        = out_pop && !out_empty;
  assign head      = ofifo[rd_ptr_r];
  assign out_blurred     = head.blurred;
  assign out_row         = head.meta.row;
  assign out_col         = head.meta.column;
  assign out_last_of_run = head.meta.last;

  assign wr_res.blurred = prod_r[DivShift +: PixW];
  assign wr_res.meta    = e3_meta_r;

  // Column step s moves the taps s places to the right; beyond the newest column
  // the right edge of the frame is repeated.
  always_comb begin
    logic [SlotW-1:0]   s;
    logic [RowSumW-1:0] acc;
    logic [2:0]         tap;
    for (int d = 0; d < 5; d++) begin
      s = slot_sel(e0_slot_r, e0_off_r, e0_rlim_r, 3'(d));
      acc = '0;
      for (int e = 0; e < 5; e++) begin
        tap = 3'(e) + 3'(e0_step_r);
        if (tap > 3'd4) tap = 3'd4;
        acc = acc + RowSumW'(Kern[d][e]) * RowSumW'(win_r[tap][s]);
      end
      rs_nxt[d] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (opq_pop) begin
      case (opq_data.kind)
        OP_FIRST: begin
          for (int e = 0; e < 5; e++) win_r[e] <= opq_data.col;
        end
        OP_SHIFT: begin
          for (int e = 0; e < 4; e++) win_r[e] <= win_r[e+1];
          win_r[4] <= opq_data.col;
        end
        default: begin
        end
      endcase
      e0_meta_r.row    <= opq_data.row;
      e0_meta_r.column <= opq_data.column;
      e0_meta_r.last   <= opq_data.last;
      e0_slot_r        <= opq_data.slot;
      e0_off_r         <= opq_data.off;
      e0_rlim_r        <= opq_data.rlim;
      e0_step_r        <= opq_data.step;
    end
    for (int d = 0; d < 5; d++) rs_r[d] <= rs_nxt[d];
    e1_meta_r <= e0_meta_r;
    sum_r <= SumW'(rs_r[0]) + SumW'(rs_r[1]) + SumW'(rs_r[2]) +
             SumW'(rs_r[3]) + SumW'(rs_r[4]);
    e2_meta_r <= e1_meta_r;
    prod_r    <= ProdW'(sum_r) * ProdW'(DivMul);
    e3_meta_r <= e2_meta_r;
    if (e3_v_r) ofifo[wr_ptr_r] <= wr_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_v_r   <= 1'b0;
      e1_v_r   <= 1'b0;
      e2_v_r   <= 1'b0;
      e3_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      e0_v_r <= opq_pop && opq_data.emit;
      e1_v_r <= e0_v_r;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      if (e3_v_r) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (OutPtrW+1)'(e3_v_r) - (OutPtrW+1)'(rd);
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPLIES(back_credit, clk, rst_n, 1'b1, ({1'b0, cnt_r} + (OutPtrW+2)'(inflight)) <= (OutPtrW+2)'(OutDepth), "results in flight exceed the result queue")
  `ASSERT_NEVER(back_ofifo_overflow, clk, rst_n, e3_v_r && !rd && (cnt_r == (OutPtrW+1)'(OutDepth)), "result queue written while full")

endmodule

// ===== src/gaussian_blur_5x5_clamped_unit.sv =====
// 5x5 Gaussian blur (kernel sum 159) with border replication on a raster pixel stream.
// Input channel: drive in_pixel with in_push; a transfer happens on a clock edge with
// in_full low. Pixels arrive in raster order for a frame of cfg width by cfg height.
// Result channel: while out_empty is low the oldest result is on out_blurred, out_row,
// out_col and out_last_of_run; out_pop takes it. last_of_run marks the final result
// caused by one input pixel.
// Configuration: cfg_we with cfg_index 0 (width) or 1 (height) writes cfg_data and
// restarts the frame at row 0, column 0; write only while the block is idle.
// Throughput: one pixel per clock in steady state. Each pixel costs one op in the
// queue between the front and the back; the last pixel of a row costs three, and
// pixels of the last row cost one op per result, so the input is held at a row end
// and for longer at the frame end.
// The window sums pass a three-register arithmetic pipe before the result queue.
// Reset clears the counters and queues and sets the frame to 2048 by 2048; the line
// store is not cleared. A stalled receiver fills the eight-entry result queue, then
// the op queue, and then in_full rises; nothing is lost.
module gaussian_blur_5x5_clamped_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gbc_pkg::CfgW-1:0]     cfg_data,
  input  logic                         in_push,
  input  gbc_pkg::pix_t                in_pixel,
  output logic                         in_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output gbc_pkg::pix_t                out_blurred,
  output logic [gbc_pkg::RowW-1:0]     out_row,
  output logic [gbc_pkg::ColW-1:0]     out_col,
  output logic                         out_last_of_run
);
  import gbc_pkg::*;

  logic opq_push;
  logic opq_full;
  logic opq_pop;
  logic opq_empty;
  op_t  opq_wdata;
  op_t  opq_rdata;

  gbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_pixel (in_pixel),
    .in_full  (in_full),
    .opq_full (opq_full),
    .opq_push (opq_push),
    .opq_data (opq_wdata)
  );

  gbc_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (opq_push),
    .push_data(opq_wdata),
    .full     (opq_full),
    .pop      (opq_pop),
    .pop_data (opq_rdata),
    .empty    (opq_empty)
  );

  gbc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .opq_empty      (opq_empty),
    .opq_data       (opq_rdata),
    .opq_pop        (opq_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_blurred    (out_blurred),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_of_run(out_last_of_run)
  );

endmodule
